// ===== hw/rtl/reader_writer_lock_scheduler_unit_macros.svh =====
// assertion macros for the reader-writer lock scheduler
// depends on nothing; included by modules that assert
`ifndef READER_WRITER_LOCK_SCHEDULER_UNIT_MACROS_SVH
`define READER_WRITER_LOCK_SCHEDULER_UNIT_MACROS_SVH
// implication checked on every edge outside reset
`define RWL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rwl check failed");
// next-cycle implication
`define RWL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rwl check failed");
`endif

// ===== hw/rtl/rwl_pkg.sv =====
// shared types and constants for the reader-writer lock scheduler
// depends on nothing
package rwl_pkg;
   localparam int QueueDepthDefault = 16;
   localparam int ExecDepthDefault  = 16;

   localparam logic [1:0] KIND_SUBMIT = 2'd0;
   localparam logic [1:0] KIND_EXEC   = 2'd1;
   localparam logic [1:0] KIND_IDLE   = 2'd2;

   typedef struct packed {
      logic accept_in;   // latch input beat
      logic do_submit;   // enqueue latched request
      logic tick_start;  // bump tick counter
      logic admit_rd;    // admit head reader
      logic admit_wr;    // admit head writer
      logic step;        // advance entry at scan index, build report
      logic idle_rpt;    // build idle report
      logic scan_clr;    // reset scan index and compaction pointer
      logic out_load;    // result register takes built report
   } ctl_type;

   typedef struct packed {
      logic is_tick;
      logic can_rd;
      logic can_wr;
      logic exec_empty;
      logic scan_done;
      logic out_busy;
   } sts_type;
endpackage

// ===== hw/rtl/rwl_datapath.sv =====
// queue memory, execution table, counters and result register
// depends on rwl_pkg and the macros header
`include "reader_writer_lock_scheduler_unit_macros.svh"
module rwl_datapath #(
   parameter int QUEUE_DEPTH = rwl_pkg::QueueDepthDefault,
   parameter int EXEC_DEPTH  = rwl_pkg::ExecDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  rwl_pkg::ctl_type   ctl,
   output rwl_pkg::sts_type   sts,
   input  logic               req_action,
   input  logic [7:0]         req_proc_id,
   input  logic               req_is_writer,
   input  logic [7:0]         req_need_time,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [7:0]         rsp_out_id,
   output logic [7:0]         rsp_run_ticks,
   output logic               rsp_finished,
   output logic               rsp_status,
   output logic [4:0]         rsp_waiting_count,
   output logic [15:0]        rsp_tick_number,
   output logic               rsp_last
);
   import rwl_pkg::*;
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = (EXEC_DEPTH > 1) ? $clog2(EXEC_DEPTH) : 1;
   localparam int EC = $clog2(EXEC_DEPTH + 1);

   // queue entry {id, writer, need}
   logic [16:0] queue_mem [QUEUE_DEPTH];
   logic [16:0] head_ff;       // registered head entry read
   logic [QW-1:0] qhead_ff, qhead_in;
   logic [QC-1:0] qcnt_ff, qcnt_in;
   logic head_ok_ff;           // head_ff mirrors current head

   logic [7:0]  e_id_ff   [EXEC_DEPTH];
   logic        e_wr_ff   [EXEC_DEPTH];
   logic [7:0]  e_need_ff [EXEC_DEPTH];
   logic [7:0]  e_run_ff  [EXEC_DEPTH];
   logic [EC-1:0] ecnt_ff;     // entries live
   logic [EC-1:0] scan_ff;     // read index
   logic [EC-1:0] keep_ff;     // compaction write index
   logic [5:0]  rdcnt_ff;
   logic        wact_ff;
   logic [15:0] tick_ff;

   logic        act_ff, iswr_ff;
   logic [7:0]  id_ff, need_ff;

   logic        ov_ff;
   logic [1:0]  o_kind_ff;
   logic [7:0]  o_id_ff, o_run_ff;
   logic        o_fin_ff, o_st_ff, o_last_ff;
   logic [4:0]  o_wc_ff;
   logic [15:0] o_tk_ff;

   logic [QW-1:0] tail;
   logic [EW-1:0] sidx, kidx, aidx;
   logic [7:0]  cur_run, new_run;
   logic        cur_fin, qfull;
   logic [QC:0] tail_sum;

   // head plus count stays below twice the depth, one subtract wraps it
   assign tail_sum = {1'b0, qhead_ff} + {1'b0, qcnt_ff};
   assign tail  = (tail_sum >= (QC+1)'(QUEUE_DEPTH)) ?
                  QW'(tail_sum - (QC+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
   assign qfull = (qcnt_ff == QC'(QUEUE_DEPTH));
   assign sidx  = scan_ff[EW-1:0];
   assign kidx  = keep_ff[EW-1:0];
   assign aidx  = ecnt_ff[EW-1:0];
   assign cur_run = e_run_ff[sidx];
   assign new_run = (cur_run == 8'hff) ? cur_run : cur_run + 8'd1;
   assign cur_fin = (new_run >= e_need_ff[sidx]);

   assign sts.is_tick    = act_ff;
   assign sts.can_rd     = head_ok_ff && (qcnt_ff != '0) && !wact_ff &&
                           (ecnt_ff < EC'(EXEC_DEPTH)) && !head_ff[8];
   assign sts.can_wr     = head_ok_ff && (qcnt_ff != '0) && !wact_ff &&
                           (ecnt_ff == '0) && head_ff[8];
   assign sts.exec_empty = (ecnt_ff == '0);
   // count shrinks on the last step when entries retire
   assign sts.scan_done  = (scan_ff >= ecnt_ff);
   assign sts.out_busy   = ov_ff && !rsp_ready;

   always_comb begin
      qhead_in = qhead_ff;
      qcnt_in  = qcnt_ff;
      if (ctl.do_submit && !qfull) qcnt_in = qcnt_ff + QC'(1);
      if (ctl.admit_rd || ctl.admit_wr) begin
         qhead_in = (qhead_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : qhead_ff + QW'(1);
         qcnt_in  = qcnt_ff - QC'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.do_submit && !qfull)
         queue_mem[tail] <= {id_ff, iswr_ff, (need_ff == 8'd0) ? 8'd1 : need_ff};
      head_ff <= queue_mem[qhead_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qhead_ff <= '0; qcnt_ff <= '0; head_ok_ff <= 1'b0;
         ecnt_ff <= '0; scan_ff <= '0; keep_ff <= '0;
         rdcnt_ff <= '0; wact_ff <= 1'b0; tick_ff <= '0; ov_ff <= 1'b0;
      end else begin
         qhead_ff <= qhead_in;
         qcnt_ff  <= qcnt_in;
         // head_ok drops after any head or memory change, until the head read is redone
         head_ok_ff <= !(ctl.admit_rd || ctl.admit_wr || ctl.do_submit);
         if (ctl.tick_start) tick_ff <= tick_ff + 16'd1;
         if (ctl.admit_rd) begin
            ecnt_ff <= ecnt_ff + EC'(1); rdcnt_ff <= rdcnt_ff + 6'd1;
         end
         if (ctl.admit_wr) begin
            ecnt_ff <= ecnt_ff + EC'(1); wact_ff <= 1'b1;
         end
         if (ctl.scan_clr) begin
            scan_ff <= '0; keep_ff <= '0;
         end
         if (ctl.step) begin
            scan_ff <= scan_ff + EC'(1);
            if (cur_fin) begin
               if (e_wr_ff[sidx]) wact_ff <= 1'b0;
               else if (rdcnt_ff != '0) rdcnt_ff <= rdcnt_ff - 6'd1;
            end else begin
               keep_ff <= keep_ff + EC'(1);
            end
            if (scan_ff + EC'(1) == ecnt_ff)
               ecnt_ff <= cur_fin ? keep_ff : keep_ff + EC'(1);
         end
         if (ctl.out_load) ov_ff <= 1'b1;
         else if (rsp_ready) ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept_in) begin
         act_ff <= req_action; id_ff <= req_proc_id;
         iswr_ff <= req_is_writer; need_ff <= req_need_time;
      end
      if (ctl.admit_rd || ctl.admit_wr) begin
         e_id_ff[aidx]   <= head_ff[16:9];
         e_wr_ff[aidx]   <= head_ff[8];
         e_need_ff[aidx] <= head_ff[7:0];
         e_run_ff[aidx]  <= 8'd0;
      end
      if (ctl.step && !cur_fin) begin
         e_id_ff[kidx]   <= e_id_ff[sidx];
         e_wr_ff[kidx]   <= e_wr_ff[sidx];
         e_need_ff[kidx] <= e_need_ff[sidx];
         e_run_ff[kidx]  <= new_run;
      end
      if (ctl.out_load) begin
         o_wc_ff <= 5'(qcnt_in);
         o_tk_ff <= tick_ff;
         if (ctl.do_submit) begin
            o_kind_ff <= KIND_SUBMIT; o_id_ff <= id_ff; o_st_ff <= qfull;
            o_run_ff <= 8'd0; o_fin_ff <= 1'b0; o_last_ff <= 1'b1;
         end else if (ctl.idle_rpt) begin
            o_kind_ff <= KIND_IDLE; o_id_ff <= 8'd0; o_st_ff <= 1'b0;
            o_run_ff <= 8'd0; o_fin_ff <= 1'b0; o_last_ff <= 1'b1;
         end else begin
            o_kind_ff <= KIND_EXEC; o_id_ff <= e_id_ff[sidx]; o_st_ff <= 1'b0;
            o_run_ff <= new_run; o_fin_ff <= cur_fin;
            o_last_ff <= (scan_ff + EC'(1) == ecnt_ff);
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_kind = o_kind_ff;
   assign rsp_out_id = o_id_ff;
   assign rsp_run_ticks = o_run_ff;
   assign rsp_finished = o_fin_ff;
   assign rsp_status = o_st_ff;
   assign rsp_waiting_count = o_wc_ff;
   assign rsp_tick_number = o_tk_ff;
   assign rsp_last = o_last_ff;

   `RWL_ASSERT_IMP(a_wr_alone, clock, reset, wact_ff, ecnt_ff == EC'(1))
   `RWL_ASSERT_IMP(a_no_step_busy, clock, reset, ctl.out_load, !sts.out_busy)
   `RWL_ASSERT_NXT(a_load_valid, clock, reset, ctl.out_load, rsp_valid)
endmodule

// ===== hw/rtl/rwl_controller.sv =====
// sequencer for submit and tick phases
// depends on rwl_pkg and the macros header
`include "reader_writer_lock_scheduler_unit_macros.svh"
module rwl_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output rwl_pkg::ctl_type ctl,
   input  rwl_pkg::sts_type sts
);
   import rwl_pkg::*;
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DEC   = 6'b000010,
      ST_WAIT  = 6'b000100,
      ST_RD    = 6'b001000,
      ST_WR    = 6'b010000,
      ST_SCAN  = 6'b100000
   } state_type;
   state_type state_ff, state_in;

   always_comb begin
      ctl = '0;
      state_in = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.accept_in = 1'b1; state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            if (!sts.is_tick) begin
               if (!sts.out_busy) begin
                  ctl.do_submit = 1'b1; ctl.out_load = 1'b1; state_in = ST_IDLE;
               end
            end else begin
               ctl.tick_start = 1'b1; state_in = ST_WAIT;
            end
         end
         ST_WAIT: state_in = ST_RD;  // head read settles
         ST_RD: begin
            if (sts.can_rd) begin
               ctl.admit_rd = 1'b1; state_in = ST_WAIT;
            end else state_in = ST_WR;
         end
         ST_WR: begin
            if (sts.can_wr) begin
               ctl.admit_wr = 1'b1; ctl.scan_clr = 1'b1; state_in = ST_SCAN;
            end else if (sts.exec_empty) begin
               if (!sts.out_busy) begin
                  ctl.idle_rpt = 1'b1; ctl.out_load = 1'b1; state_in = ST_IDLE;
               end
            end else begin
               ctl.scan_clr = 1'b1; state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) state_in = ST_IDLE;
            else if (!sts.out_busy) begin
               ctl.step = 1'b1; ctl.out_load = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   `RWL_ASSERT_IMP(a_one_admit, clock, reset, ctl.admit_rd, !ctl.admit_wr && !ctl.step)
   `RWL_ASSERT_NXT(a_accept_dec, clock, reset, ctl.accept_in, state_ff == ST_DEC)
   `RWL_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, !ctl.out_load)
endmodule

// ===== hw/rtl/reader_writer_lock_scheduler_unit.sv =====
// top level of the reader-writer lock scheduler
// depends on rwl_pkg, rwl_controller and rwl_datapath
//
// Readers-writers lock arbiter. A submit beat (action 0) queues a request in a
// FIFO and answers with one beat (status 1 when the queue is full). A tick beat
// (action 1) admits head readers while no writer runs, then a head writer only
// into an empty table, then reports every executing entry in admission order
// (finished marks those leaving) or one idle beat; last marks the final beat.
// A submit is answered from the decode state; a tick passes the wait, read and
// writer states, then the scan or the idle beat, paced by the single queue read
// port (one registered head read per admission) and the one-entry-a-cycle table
// scan. A head writer goes straight into the scan, with no wait state after it.
// One item is worked at a time; a stalled result beat holds the scan.
module reader_writer_lock_scheduler_unit #(
   parameter int QUEUE_DEPTH = rwl_pkg::QueueDepthDefault,
   parameter int EXEC_DEPTH  = rwl_pkg::ExecDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_proc_id,
   input  logic        req_is_writer,
   input  logic [7:0]  req_need_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_out_id,
   output logic [7:0]  rsp_run_ticks,
   output logic        rsp_finished,
   output logic        rsp_status,
   output logic [4:0]  rsp_waiting_count,
   output logic [15:0] rsp_tick_number,
   output logic        rsp_last
);
   import rwl_pkg::*;

   ctl_type ctl;
   sts_type sts;

   rwl_controller u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .ctl, .sts
   );

   rwl_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .EXEC_DEPTH(EXEC_DEPTH)) u_dp (
      .clock, .reset, .ctl, .sts,
      .req_action, .req_proc_id, .req_is_writer, .req_need_time,
      .rsp_valid, .rsp_ready, .rsp_kind, .rsp_out_id, .rsp_run_ticks,
      .rsp_finished, .rsp_status, .rsp_waiting_count, .rsp_tick_number, .rsp_last
   );
endmodule

// ===== test/tb_reader_writer_lock_scheduler_unit.sv =====
// testbench for the reader-writer lock scheduler: directed and random beats
// checked against a behavioral lock and queue predictor
// depends on rwl_pkg and reader_writer_lock_scheduler_unit
`timescale 1ns / 1ps

module tb_reader_writer_lock_scheduler_unit;
   import rwl_pkg::*;

   localparam int QDEPTH = 16;
   localparam int EDEPTH = 16;
   localparam logic ACT_SUBMIT = 1'b0;
   localparam logic ACT_TICK   = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [7:0]  req_proc_id = 8'd0;
   logic        req_is_writer = 1'b0;
   logic [7:0]  req_need_time = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_out_id;
   logic [7:0]  rsp_run_ticks;
   logic        rsp_finished;
   logic        rsp_status;
   logic [4:0]  rsp_waiting_count;
   logic [15:0] rsp_tick_number;
   logic        rsp_last;

   reader_writer_lock_scheduler_unit uut (.*);

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // one expected result beat
   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  id;
      logic [7:0]  run;
      logic        fin;
      logic        status;
      logic [4:0]  waiting;
      logic [15:0] tick;
      logic        last;
   } sched_beat_type;

   sched_beat_type pending_beats[$];
   int errors = 0;

   // idle percentages and the long receiver hold-off
   int send_idle = 0;
   int recv_idle = 0;
   int hold_cycles = 0;

   // predictor state
   logic [7:0]  wq_id[QDEPTH];
   logic        wq_wr[QDEPTH];
   logic [7:0]  wq_need[QDEPTH];
   int          wq_head = 0;
   int          wq_count = 0;
   logic [7:0]  ex_id[EDEPTH];
   logic        ex_wr[EDEPTH];
   logic [7:0]  ex_need[EDEPTH];
   logic [7:0]  ex_run[EDEPTH];
   int          ex_count = 0;
   int          readers_running = 0;
   logic        writer_running = 1'b0;
   logic [15:0] tick_count = 16'd0;

   function automatic void push_beat(logic [1:0] kind, logic [7:0] id, logic [7:0] run,
                                     logic fin, logic status, logic last);
      sched_beat_type b;
      b.kind = kind; b.id = id; b.run = run; b.fin = fin; b.status = status;
      b.waiting = wq_count[4:0]; b.tick = tick_count; b.last = last;
      pending_beats.push_back(b);
   endfunction

   // move the queue head into the execution table
   function automatic void admit_head();
      ex_id[ex_count] = wq_id[wq_head];
      ex_wr[ex_count] = wq_wr[wq_head];
      ex_need[ex_count] = wq_need[wq_head];
      ex_run[ex_count] = 8'd0;
      ex_count++;
      wq_head = (wq_head + 1) % QDEPTH;
      wq_count--;
   endfunction

   function automatic void predict_scheduler(logic act, logic [7:0] id, logic wr,
                                             logic [7:0] need);
      int slot;
      int kept;
      logic [7:0] n;
      n = (need == 8'd0) ? 8'd1 : need;
      if (act == ACT_SUBMIT) begin
         if (wq_count < QDEPTH) begin
            slot = (wq_head + wq_count) % QDEPTH;
            wq_id[slot] = id; wq_wr[slot] = wr; wq_need[slot] = n;
            wq_count++;
            push_beat(KIND_SUBMIT, id, 8'd0, 1'b0, 1'b0, 1'b1);
         end else begin
            push_beat(KIND_SUBMIT, id, 8'd0, 1'b0, 1'b1, 1'b1);
         end
         return;
      end
      tick_count = tick_count + 16'd1;
      // readers at the head while no writer holds the lock
      while (wq_count > 0 && !writer_running && ex_count < EDEPTH && !wq_wr[wq_head]) begin
         admit_head();
         readers_running++;
      end
      // head writer only into an empty table
      if (wq_count > 0 && ex_count == 0 && !writer_running && wq_wr[wq_head]) begin
         admit_head();
         writer_running = 1'b1;
      end
      if (ex_count == 0) begin
         push_beat(KIND_IDLE, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1);
         return;
      end
      for (int i = 0; i < ex_count; i++) begin
         if (ex_run[i] != 8'hFF) ex_run[i]++;
         push_beat(KIND_EXEC, ex_id[i], ex_run[i], ex_run[i] >= ex_need[i], 1'b0,
                   i + 1 == ex_count);
      end
      // retire finished entries, keep admission order
      kept = 0;
      for (int i = 0; i < ex_count; i++) begin
         if (ex_run[i] >= ex_need[i]) begin
            if (ex_wr[i]) writer_running = 1'b0;
            else if (readers_running > 0) readers_running--;
         end else begin
            ex_id[kept] = ex_id[i]; ex_wr[kept] = ex_wr[i];
            ex_need[kept] = ex_need[i]; ex_run[kept] = ex_run[i];
            kept++;
         end
      end
      ex_count = kept;
   endfunction

   // offer one beat, with random idle cycles before it
   task automatic send_beat(logic act, logic [7:0] id, logic wr, logic [7:0] need);
      while ($urandom_range(99) < send_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_action = act; req_proc_id = id; req_is_writer = wr; req_need_time = need;
      do @(posedge clock); while (!req_ready);
      predict_scheduler(act, id, wr, need);
      @(negedge clock);
   endtask

   task automatic submit(logic [7:0] id, logic wr, logic [7:0] need);
      send_beat(ACT_SUBMIT, id, wr, need);
   endtask

   // tick with random content in the ignored fields
   task automatic tick();
      send_beat(ACT_TICK, 8'($urandom), 1'($urandom), 8'($urandom));
   endtask

   // receiver ready, with a counted hold-off when asked
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin
      sched_beat_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected beat kind %0d id %0d", $time, rsp_kind, rsp_out_id);
            errors++;
         end else begin
            e = pending_beats.pop_front();
            if ({rsp_kind, rsp_out_id, rsp_run_ticks, rsp_finished, rsp_status,
                 rsp_waiting_count, rsp_tick_number, rsp_last} !==
                {e.kind, e.id, e.run, e.fin, e.status, e.waiting, e.tick, e.last}) begin
               $display("%0t: mismatch exp kind %0d id %0d run %0d fin %0d st %0d wait %0d tick %0d last %0d",
                        $time, e.kind, e.id, e.run, e.fin, e.status, e.waiting, e.tick, e.last);
               $display("%0t:          act kind %0d id %0d run %0d fin %0d st %0d wait %0d tick %0d last %0d",
                        $time, rsp_kind, rsp_out_id, rsp_run_ticks, rsp_finished, rsp_status,
                        rsp_waiting_count, rsp_tick_number, rsp_last);
               errors++;
            end
         end
      end
   end

   // tick until the table and queue are empty
   task automatic drain_lock();
      while (ex_count > 0 || wq_count > 0) tick();
   endtask

   // idle tick, field extremes, zero service time, queue full
   task automatic test_submit_edges();
      tick();
      submit(8'd0, 1'b0, 8'd0);
      submit(8'd255, 1'b1, 8'd1);
      for (int i = 0; i < 15; i++) submit(8'(i + 1), 1'b0, 8'd2);
      drain_lock();
   endtask

   // writer waits behind active readers, then a longer writer
   task automatic test_writer_behind_readers();
      submit(8'd10, 1'b0, 8'd3);
      submit(8'd11, 1'b0, 8'd1);
      submit(8'd12, 1'b1, 8'd2);
      submit(8'd13, 1'b0, 8'd1);
      tick();
      tick();
      submit(8'd14, 1'b1, 8'd6);
      drain_lock();
   endtask

   // execution table full, head reader stays queued
   task automatic test_table_full();
      for (int i = 0; i < 16; i++) submit(8'(32 + i), 1'b0, 8'd4);
      tick();
      for (int i = 0; i < 3; i++) submit(8'(64 + i), 1'b0, 8'd1);
      tick();
      drain_lock();
   endtask

   // receiver holds off while the sender keeps offering beats
   task automatic test_backpressure();
      hold_cycles = 300;
      for (int i = 0; i < 24; i++) submit(8'($urandom), 1'($urandom), 8'($urandom_range(3)));
      for (int i = 0; i < 6; i++) tick();
      drain_lock();
   endtask

   // mostly well-formed traffic with short service, a few full-range beats
   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 45) tick();
         else if ($urandom_range(99) < 5)
            submit(8'($urandom), 1'($urandom), 8'($urandom));
         else
            submit(8'($urandom), $urandom_range(99) < 30, 8'($urandom_range(4)));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle = 32; recv_idle = 59;
      test_submit_edges();
      test_writer_behind_readers();
      test_table_full();
      test_backpressure();
      test_random(80);
      send_idle = 59; recv_idle = 32;
      test_random(80);
      send_idle = 0; recv_idle = 0;
      test_random(80);
      req_valid = 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule

// ===== reader_writer_lock_scheduler_unit.f =====
+incdir+hw/rtl
hw/rtl/rwl_pkg.sv
hw/rtl/rwl_datapath.sv
hw/rtl/rwl_controller.sv
hw/rtl/reader_writer_lock_scheduler_unit.sv
test/tb_reader_writer_lock_scheduler_unit.sv
